// File: sv/lru_pkg.sv
// ---------------------------------------------------------------------------
// lru_pkg : shared types and constants for the lru page replacement block
// Holds the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

  // fixed field widths of the external interface
  localparam int EXT_PAGE_W  = 16;
  localparam int FRAME_IDX_W = 4;
  localparam int CFG_W       = 5;
  localparam int FAULT_W     = 16;

  localparam logic [FAULT_W-1:0] FAULT_MAX       = 16'hFFFF;
  localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = 5'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;       // latch a new page reference
    logic step;         // issue the next memory read of a scan
    logic shift;        // promote pass: move recency entries down
    logic hit_found;    // scan matched, record frame and start promote
    logic fill;         // fill the next empty frame
    logic ro_zero;      // read the oldest recency entry
    logic ev_frame;     // take the victim frame from the recency read
    logic ev_page;      // capture victim page and overwrite the frame
    logic promote_end;  // append the frame as most recent
    logic load_out;     // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;   // scan counter below the filled count
    logic pend;   // a read was issued last cycle
    logic match;  // pending page read equals the reference
    logic full;   // no empty frame within the frame count
  } status_t;

endpackage

`default_nettype wire

// File: sv/lru_ctrl.sv
// ---------------------------------------------------------------------------
// lru_ctrl : sequencing state machine of the lru page replacement block
// Steps a reference: scan; fill, or evict then promote, or promote; result.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire lru_pkg::status_t status,
  output lru_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_EV_RD,
    S_EV_FRAME,
    S_EV_PAGE,
    S_PROMOTE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.match) begin
          cmd.hit_found = 1'b1;
          state_nxt     = S_PROMOTE;
        end else if (!status.more && !status.pend) begin
          state_nxt = status.full ? S_EV_RD : S_FILL;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_EV_RD: begin
        cmd.ro_zero = 1'b1;
        state_nxt   = S_EV_FRAME;
      end
      S_EV_FRAME: begin
        cmd.ev_frame = 1'b1;
        state_nxt    = S_EV_PAGE;
      end
      S_EV_PAGE: begin
        cmd.ev_page = 1'b1;
        state_nxt   = S_PROMOTE;
      end
      S_PROMOTE: begin
        if (!status.more && !status.pend) begin
          cmd.promote_end = 1'b1;
          state_nxt       = S_FINISH;
        end else begin
          cmd.step  = 1'b1;
          cmd.shift = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: sv/lru_dpath.sv
// ---------------------------------------------------------------------------
// lru_dpath : frame store, recency queue and counters of the lru block
// Page and recency memories with registered reads, scan and result logic.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_dpath #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lru_pkg::cmd_t                         cmd,
  output lru_pkg::status_t                           status,
  input  wire logic [lru_pkg::EXT_PAGE_W-1:0]        in_page_number,
  input  wire logic                                  cfg_valid,
  input  wire logic [lru_pkg::CFG_W-1:0]             cfg_frame_count,
  output logic                                       out_hit,
  output logic [lru_pkg::FRAME_IDX_W-1:0]            out_frame_index,
  output logic                                       out_evicted_valid,
  output logic [lru_pkg::EXT_PAGE_W-1:0]             out_evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]                out_fault_total
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int LW = (CW > lru_pkg::CFG_W) ? CW : lru_pkg::CFG_W;

  // storage
  logic [PAGE_BITS-1:0] page_mem [MAX_FRAMES];
  logic [FW-1:0]        ro_mem   [MAX_FRAMES];

  logic [lru_pkg::CFG_W-1:0]   frame_count_r;
  logic [CW-1:0]               filled_r;
  logic [lru_pkg::FAULT_W-1:0] fault_r;
  logic [CW-1:0]               k_r;
  logic [FW-1:0]               kd_r;
  logic                        pend_r;
  logic                        found_r;
  logic [FW-1:0]               f_r;
  logic [PAGE_BITS-1:0]        page_r;
  logic                        hit_r;
  logic                        ev_valid_r;
  logic [PAGE_BITS-1:0]        ev_page_r;
  logic [PAGE_BITS-1:0]        page_rdata_r;
  logic [FW-1:0]               ro_rdata_r;

  logic                        out_hit_r;
  logic [lru_pkg::FRAME_IDX_W-1:0] out_frame_index_r;
  logic                        out_evicted_valid_r;
  logic [lru_pkg::EXT_PAGE_W-1:0]  out_evicted_page_r;
  logic [lru_pkg::FAULT_W-1:0] out_fault_total_r;

  // combinational helpers
  logic [PAGE_BITS+lru_pkg::EXT_PAGE_W-1:0] in_wide;
  logic [PAGE_BITS+lru_pkg::EXT_PAGE_W-1:0] ev_wide;
  logic [FW+lru_pkg::FRAME_IDX_W-1:0]       frame_wide;
  logic [LW-1:0]               cnt_ext;
  logic [LW-1:0]               limit;
  logic [FW-1:0]               page_raddr;
  logic [FW-1:0]               ro_raddr;
  logic [FW-1:0]               filled_idx;
  logic [FW-1:0]               last_idx;
  logic                        page_we;
  logic [FW-1:0]               page_waddr;
  logic                        ro_we;
  logic [FW-1:0]               ro_waddr;
  logic [FW-1:0]               ro_wdata;
  logic                        shift_wr;
  logic                        fault_inc;

  assign in_wide    = {{PAGE_BITS{1'b0}}, in_page_number};
  assign ev_wide    = {{lru_pkg::EXT_PAGE_W{1'b0}}, ev_page_r};
  assign frame_wide = {{lru_pkg::FRAME_IDX_W{1'b0}}, f_r};
  assign filled_idx = filled_r[FW-1:0];
  assign last_idx   = FW'(filled_r - CW'(1));

  // effective frame count, zero acts as one and large values clip
  always_comb begin
    cnt_ext = LW'(frame_count_r);
    if (cnt_ext == '0) begin
      limit = LW'(1);
    end else if (cnt_ext > LW'(MAX_FRAMES)) begin
      limit = LW'(MAX_FRAMES);
    end else begin
      limit = cnt_ext;
    end
  end

  assign status.more  = (k_r < filled_r);
  assign status.pend  = pend_r;
  assign status.match = pend_r && (page_rdata_r == page_r);
  assign status.full  = (LW'(filled_r) >= limit);

  assign page_raddr = cmd.ev_frame ? ro_rdata_r : k_r[FW-1:0];
  assign ro_raddr   = cmd.ro_zero ? '0 : k_r[FW-1:0];

  assign shift_wr  = cmd.shift && pend_r && found_r;
  assign fault_inc = cmd.fill || cmd.ev_page;

  // write port muxes
  always_comb begin
    page_we    = cmd.fill || cmd.ev_page;
    page_waddr = cmd.fill ? filled_idx : f_r;
    ro_we      = cmd.fill || cmd.promote_end || shift_wr;
    ro_waddr   = kd_r - FW'(1);
    ro_wdata   = ro_rdata_r;
    if (cmd.fill) begin
      ro_waddr = filled_idx;
      ro_wdata = filled_idx;
    end else if (cmd.promote_end) begin
      ro_waddr = last_idx;
      ro_wdata = f_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (page_we) begin
      page_mem[page_waddr] <= page_r;
    end
    page_rdata_r <= page_mem[page_raddr];
  end

  always_ff @(posedge clk) begin
    if (ro_we) begin
      ro_mem[ro_waddr] <= ro_wdata;
    end
    ro_rdata_r <= ro_mem[ro_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= lru_pkg::FRAME_COUNT_RST;
      filled_r      <= '0;
      fault_r       <= '0;
      k_r           <= '0;
      pend_r        <= 1'b0;
      found_r       <= 1'b0;
      hit_r         <= 1'b0;
      ev_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_count_r <= cfg_frame_count;
      end
      if (cmd.fill) begin
        filled_r <= filled_r + CW'(1);
      end
      if (fault_inc && (fault_r != lru_pkg::FAULT_MAX)) begin
        fault_r <= fault_r + lru_pkg::FAULT_W'(1);
      end
      if (cmd.accept || cmd.hit_found || cmd.ev_page) begin
        k_r     <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end else if (cmd.step) begin
        if (k_r < filled_r) begin
          k_r    <= k_r + CW'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (cmd.shift && pend_r && (ro_rdata_r == f_r)) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.accept) begin
        hit_r      <= 1'b0;
        ev_valid_r <= 1'b0;
      end else if (cmd.hit_found) begin
        hit_r <= 1'b1;
      end else if (cmd.ev_page) begin
        ev_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      kd_r <= k_r[FW-1:0];
    end
    if (cmd.accept) begin
      page_r    <= in_wide[PAGE_BITS-1:0];
      ev_page_r <= '0;
    end
    if (cmd.hit_found) begin
      f_r <= kd_r;
    end else if (cmd.fill) begin
      f_r <= filled_idx;
    end else if (cmd.ev_frame) begin
      f_r <= ro_rdata_r;
    end
    if (cmd.ev_page) begin
      ev_page_r <= page_rdata_r;
    end
    if (cmd.load_out) begin
      out_hit_r           <= hit_r;
      out_frame_index_r   <= frame_wide[lru_pkg::FRAME_IDX_W-1:0];
      out_evicted_valid_r <= ev_valid_r;
      out_evicted_page_r  <= ev_wide[lru_pkg::EXT_PAGE_W-1:0];
      out_fault_total_r   <= fault_r;
    end
  end

  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_total   = out_fault_total_r;

  // checks
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CW'(MAX_FRAMES))
    else $error("filled frame count beyond capacity");

  a_fill_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> !status.full)
    else $error("fill issued with no empty frame");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit_r && ev_valid_r))
    else $error("hit and eviction on the same reference");

  a_fault_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(fault_inc) |-> $stable(fault_r))
    else $error("fault count moved without a miss");

endmodule

`default_nettype wire

// File: sv/lru_page_replacement.sv
// ---------------------------------------------------------------------------
// lru_page_replacement : least recently used page replacement engine
// Resolves page references against a set of frames with true lru eviction.
// ---------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_stall     | in_page_number
//  out      | out_valid / out_stall   | out_hit, out_frame_index,
//           |                         | out_evicted_valid, out_evicted_page,
//           |                         | out_fault_total
//  cfg      | cfg_valid / cfg_ready   | cfg_frame_count
//
//  one reference at a time; a hit scans up to its frame, then promotes it;
//  a miss scans every filled frame, then fills an empty frame, or evicts
//  the oldest and promotes the new page; the single read port of the page
//  and recency memories sets the pace: one frame compared, then one
//  recency entry moved, per cycle
//  no clearing pass after reset: the filled count marks the valid frames
//  in_stall is high while a reference is being worked on; a loaded result
//  waits in the output register, so the next reference is taken meanwhile
//  cfg_ready is always high; write only while the block is idle
// ---------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // page reference transactions
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [lru_pkg::EXT_PAGE_W-1:0]     in_page_number,
  // result transactions
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic [lru_pkg::FRAME_IDX_W-1:0]         out_frame_index,
  output logic                                    out_evicted_valid,
  output logic [lru_pkg::EXT_PAGE_W-1:0]          out_evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]             out_fault_total,
  // frame count register write
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lru_pkg::CFG_W-1:0]          cfg_frame_count
);

  lru_pkg::cmd_t    cmd;
  lru_pkg::status_t status;

  // user writes the register only between transactions (the block does not enforce it), so never hold it off
  assign cfg_ready = 1'b1;

  // sequencing: scan; fill, or evict then promote, or promote on a hit; result
  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // frame store, recency queue, counters and result register
  lru_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_page_number    (in_page_number),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_frame_count   (cfg_frame_count),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

endmodule

`default_nettype wire

// File: dv/lru_page_replacement_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_page_replacement_tb : self-checking bench for the lru page replacement
// Page references go in through the valid/stall channel. A local copy of the
// frame table, recency list and fault counter predicts every outcome, and
// each result transaction is compared field by field. The bench covers
// directed corner cases, a single frame, frame count clamping,
// random traffic under several idle/stall mixes and a long output hold-off.
// ---------------------------------------------------------------------------

module lru_page_replacement_tb;

  localparam int NUM_FRAMES   = 16;
  localparam int SETTLE_CYCLES = 2 * NUM_FRAMES + 16;  // worst miss plus margin
  localparam int PHASE_ITEMS  = 232;
  localparam int TIMEOUT_NS   = 80_000_000;

  // one predicted outcome per page reference
  typedef struct packed {
    logic                            hit;
    logic [lru_pkg::FRAME_IDX_W-1:0] frame;
    logic                            ev_valid;
    logic [lru_pkg::EXT_PAGE_W-1:0]  ev_page;
    logic [lru_pkg::FAULT_W-1:0]     faults;
  } page_outcome_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [lru_pkg::EXT_PAGE_W-1:0]  in_page_number = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_hit;
  logic [lru_pkg::FRAME_IDX_W-1:0] out_frame_index;
  logic                            out_evicted_valid;
  logic [lru_pkg::EXT_PAGE_W-1:0]  out_evicted_page;
  logic [lru_pkg::FAULT_W-1:0]     out_fault_total;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lru_pkg::CFG_W-1:0]       cfg_frame_count = '0;

  // predictor state: frame table, recency list (oldest first), counters
  logic [lru_pkg::CFG_W-1:0]       frame_count_q = lru_pkg::FRAME_COUNT_RST;
  logic [lru_pkg::EXT_PAGE_W-1:0]  frame_page_m [NUM_FRAMES];
  bit                              frame_used_m [NUM_FRAMES];
  int unsigned                     lru_list_m   [NUM_FRAMES];
  int unsigned                     filled_m = 0;
  logic [lru_pkg::FAULT_W-1:0]     faults_m = '0;

  page_outcome_t          outcome_q [$];
  page_outcome_t          want_outcome;
  int unsigned            mismatches = 0;

  // traffic shaping, percentages per cycle
  int unsigned            send_idle_pct  = 0;
  int unsigned            recv_stall_pct = 0;
  int unsigned            hold_off_left  = 0;

  lru_page_replacement #(
    .MAX_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (lru_pkg::EXT_PAGE_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frame_count   (cfg_frame_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // drop the entry at position pos and append frame fr as most recent
  function automatic void make_recent(input int unsigned pos, input int unsigned fr);
    for (int unsigned k = pos; k + 1 < filled_m; k++)
      lru_list_m[k] = lru_list_m[k + 1];
    lru_list_m[filled_m - 1] = fr;
  endfunction

  function automatic page_outcome_t resolve_reference(
    input logic [lru_pkg::EXT_PAGE_W-1:0] pg
  );
    page_outcome_t r;
    int unsigned   limit;
    int unsigned   pos;
    int unsigned   fr;
    bit            found;
    r     = '0;
    found = 1'b0;
    pos   = 0;
    fr    = 0;
    // zero behaves as one frame, anything past the table as the full table
    if (frame_count_q == 0)
      limit = 1;
    else if (frame_count_q > NUM_FRAMES)
      limit = NUM_FRAMES;
    else
      limit = frame_count_q;
    // scan resident frames from oldest to newest
    for (int unsigned k = 0; k < filled_m; k++) begin
      if (!found && frame_used_m[lru_list_m[k]] && frame_page_m[lru_list_m[k]] == pg) begin
        found = 1'b1;
        pos   = k;
        fr    = lru_list_m[k];
      end
    end
    if (found) begin
      r.hit = 1'b1;
      make_recent(pos, fr);
    end else begin
      if (faults_m != lru_pkg::FAULT_MAX)
        faults_m++;
      if (filled_m < limit) begin
        // still room: next empty frame in index order
        fr               = filled_m;
        frame_page_m[fr] = pg;
        frame_used_m[fr] = 1'b1;
        lru_list_m[fr]   = fr;
        filled_m++;
      end else begin
        // evict the oldest, also when the frame count was lowered below filled
        fr               = lru_list_m[0];
        r.ev_valid       = 1'b1;
        r.ev_page        = frame_page_m[fr];
        frame_page_m[fr] = pg;
        frame_used_m[fr] = 1'b1;
        make_recent(0, fr);
      end
    end
    r.frame  = lru_pkg::FRAME_IDX_W'(fr);
    r.faults = faults_m;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // result side: stall generation and checking
  // ------------------------------------------------------------------------

  // long hold-off takes priority over the random stall rate
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, expected none, actual %0h",
                 $time, {out_hit, out_frame_index, out_evicted_valid, out_evicted_page,
                         out_fault_total});
        mismatches++;
      end else begin
        want_outcome = outcome_q.pop_front();
        check_field("hit", want_outcome.hit, out_hit);
        check_field("frame_index", want_outcome.frame, out_frame_index);
        check_field("evicted_valid", want_outcome.ev_valid, out_evicted_valid);
        check_field("evicted_page", want_outcome.ev_page, out_evicted_page);
        check_field("fault_total", want_outcome.faults, out_fault_total);
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // present one page reference, optionally after an idle gap
  task automatic offer_page(input logic [lru_pkg::EXT_PAGE_W-1:0] pg);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_page_number <= pg;
    do @(posedge clk); while (in_stall);
    outcome_q.push_back(resolve_reference(pg));
  endtask

  // block idle: every result back and the last reference settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [lru_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_valid       <= 1'b1;
    cfg_frame_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    frame_count_q  = value;
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset frame count of three, page extremes, then zero acting as one
  // with more frames already filled than the count allows
  task automatic test_reset_defaults();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    offer_page(16'h0000);
    offer_page(16'hFFFF);
    offer_page(16'h0000);
    offer_page(16'h5A5A);
    offer_page(16'hA5A5);   // fourth distinct page, evicts under the reset count
    offer_page(16'h0000);
    offer_page(16'hFFFF);
    write_frame_count(5'd0);
    offer_page(16'hA5A5);   // still resident after lowering
    offer_page(16'h0000);
    offer_page(16'h1234);
    offer_page(16'h1234);
  endtask

  // one frame, a run of fresh pages that each evict the oldest, then a hit
  task automatic test_single_frame();
    logic [lru_pkg::EXT_PAGE_W-1:0] pg;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_frame_count(5'd1);
    pg = 16'h2000;
    repeat (40) begin
      offer_page(pg);
      pg++;
    end
    offer_page(pg - 1'b1);  // newest page is resident, a hit
    repeat (4) begin
      offer_page(pg);
      pg++;
    end
  endtask

  // count beyond the table acts as the full table: fill up, then evict
  task automatic test_frame_count_clamp();
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    write_frame_count(5'd31);
    for (int i = 0; i < 14; i++)
      offer_page(16'h0100 + 16'(i));
    offer_page(16'h0105);
  endtask

  // working-set traffic with occasional wide pages, per idle mix
  task automatic test_random_traffic();
    logic [lru_pkg::EXT_PAGE_W-1:0] pool [32];
    logic [lru_pkg::CFG_W-1:0]      counts [8];
    int unsigned                    ws;
    int unsigned                    roll;
    counts = '{5'd1, 5'd0, 5'd3, 5'd31, 5'd16, 5'd7, 5'd2, 5'd0};
    counts[7] = lru_pkg::CFG_W'($urandom_range(0, 31));
    for (int ph = 0; ph < 8; ph++) begin
      write_frame_count(counts[ph]);
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      foreach (pool[i])
        pool[i] = lru_pkg::EXT_PAGE_W'($urandom);
      ws = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // shift the working set now and then
        if (n % 61 == 60)
          ws = $urandom_range(1, 24);
        roll = $urandom_range(99);
        if (roll < 80)
          offer_page(pool[$urandom_range(0, ws - 1)]);
        else if (roll < 95)
          offer_page(lru_pkg::EXT_PAGE_W'($urandom));
        else
          offer_page($urandom_range(1) ? 16'hFFFF : 16'h0000);
      end
    end
  endtask

  // receiver holds off for a long stretch while references keep coming
  task automatic test_input_backpressure();
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 400;
    repeat (24)
      offer_page(lru_pkg::EXT_PAGE_W'($urandom));
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_single_frame();
    test_frame_count_clamp();
    test_random_traffic();
    test_input_backpressure();
    wait_idle();
    if (mismatches == 0 && outcome_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
